[hdl/pph_pkg.sv]
`timescale 1ns / 1ps

package pph_pkg;

    localparam int FUNC_W   = 2;
    localparam int HASH_W   = 32;
    localparam int KEY_IN_W = 32;
    localparam int VAL_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int BUCKET_W = 10;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_SPARE  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

endpackage

[hdl/pph_if.sv]
`timescale 1ns / 1ps

interface pph_req_if;
    import pph_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [HASH_W-1:0]   hash;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_IN_W-1:0] entry_value;

    modport source (output valid, output func, output hash, output key, output entry_value,
                    input ready);
    modport sink   (input valid, input func, input hash, input key, input entry_value,
                    output ready);
endinterface

interface pph_rsp_if;
    import pph_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [VAL_IN_W-1:0] found_value;

    modport source (output valid, output status, output bucket, output found_value,
                    input ready);
    modport sink   (input valid, input status, input bucket, input found_value,
                    output ready);
endinterface

[hdl/perturbed_probe_hash_table.sv]
`timescale 1ns / 1ps

// channel   | dir | handshake     | payload
// i_req     | in  | valid / ready | func, hash, key, entry_value
// o_rsp     | out | valid / ready | status, bucket, found_value
// i_cfg_wr  | in  | write enable  | bucket_bits_in_use (4 bits)
//
// lookup / insert: accepted in S_IDLE, then S_CHECK probes one bucket after another, each
// probe a read of the bucket memory (at most 2^BUCKET_BITS + 8 probes)
// clear: sweeps all 2^BUCKET_BITS buckets, one bucket written per cycle, then the result
// reset: the same sweep of all 2^BUCKET_BITS buckets, during which i_req.ready is low
// a result waiting on o_rsp stalls the next item only at its final probe

module perturbed_probe_hash_table #(
    parameter int BUCKET_BITS = 10,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [pph_pkg::CFG_W-1:0] i_cfg_wr_data,
    pph_req_if.sink                   i_req,
    pph_rsp_if.source                 o_rsp
);
    import pph_pkg::*;

    localparam int NUM_SLOTS   = 2 ** BUCKET_BITS;
    localparam int PROBE_LIMIT = NUM_SLOTS + 8;
    localparam int STEP_W      = $clog2(PROBE_LIMIT);
    localparam int CNT_W       = BUCKET_BITS + 1;

    typedef struct packed {
        logic                   used;
        logic [HASH_W-1:0]      hash;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_CHECK
    } t_state;

    t_slot r_mem [NUM_SLOTS];
    t_slot r_q;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [BUCKET_BITS-1:0] r_sweep;
    logic                   r_report;
    logic [CNT_W-1:0]       r_count;
    logic [HASH_W-1:0]      r_idx;
    logic [HASH_W-1:0]      r_pert;
    logic [STEP_W-1:0]      r_steps;
    logic                   r_ins;
    logic [HASH_W-1:0]      r_hash;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_val;

    logic                   r_out_valid;
    t_status                r_status;
    logic [BUCKET_W-1:0]    r_bucket;
    logic [VAL_IN_W-1:0]    r_value;

    logic [4:0]             w_bits;
    logic [CNT_W-1:0]       w_nbuckets;
    logic [BUCKET_BITS-1:0] w_mask;
    logic [HASH_W-1:0]      n_idx;
    logic [HASH_W-1:0]      n_pert;
    logic [BUCKET_BITS-1:0] w_b;
    logic                   w_hit;
    logic                   w_last;
    logic                   w_fin;
    logic                   w_room;
    logic                   w_slot_free;
    logic                   w_do_ins;
    logic                   w_emit;
    t_status                w_status;
    logic [BUCKET_W-1:0]    w_bucket;
    logic [VAL_IN_W-1:0]    w_value;
    logic [31:0]            w_b_ext;
    logic [63:0]            w_val_ext;
    logic [63:0]            w_key_in;
    logic [63:0]            w_val_in;
    logic [BUCKET_BITS-1:0] w_rd_addr;
    logic                   w_we;
    logic [BUCKET_BITS-1:0] w_wr_addr;
    t_slot                  w_wr_data;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.bucket      = r_bucket;
    assign o_rsp.found_value = r_value;

    always_comb begin
        if (r_cfg == '0) begin
            w_bits = 5'd1;
        end else if (32'(r_cfg) > BUCKET_BITS) begin
            w_bits = 5'(BUCKET_BITS);
        end else begin
            w_bits = 5'(r_cfg);
        end
        w_nbuckets = CNT_W'(1) << w_bits;
        w_mask     = BUCKET_BITS'(w_nbuckets - CNT_W'(1));

        n_idx  = (r_idx << 2) + r_idx + r_pert + 32'd1;
        n_pert = r_pert >> 5;
        w_b    = r_idx[BUCKET_BITS-1:0] & w_mask;

        w_hit       = r_q.used && (r_q.hash == r_hash) && (r_q.key == r_key);
        w_last      = (r_steps == STEP_W'(PROBE_LIMIT - 1));
        w_fin       = !r_q.used || w_hit || w_last;
        w_room      = ((CNT_W + 1)'(r_count) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(w_nbuckets);
        w_slot_free = !r_out_valid || o_rsp.ready;

        w_b_ext   = 32'(w_b);
        w_val_ext = 64'(r_q.value);
        w_key_in  = 64'(i_req.key);
        w_val_in  = 64'(i_req.entry_value);

        w_bucket = '0;
        w_value  = '0;
        if (!r_q.used) begin
            if (!r_ins) begin
                w_status = ST_MISS;
            end else if (w_room) begin
                w_status = ST_INSERTED;
                w_bucket = w_b_ext[BUCKET_W-1:0];
            end else begin
                w_status = ST_FULL;
            end
        end else if (w_hit) begin
            if (r_ins) begin
                w_status = ST_DUPLICATE;
            end else begin
                w_status = ST_FOUND;
                w_bucket = w_b_ext[BUCKET_W-1:0];
                w_value  = w_val_ext[VAL_IN_W-1:0];
            end
        end else begin
            w_status = r_ins ? ST_FULL : ST_MISS;
        end

        w_do_ins = (r_state == S_CHECK) && w_slot_free && !r_q.used && r_ins && w_room;
        w_emit   = ((r_state == S_CHECK) && w_fin && w_slot_free)
                   || ((r_state == S_SWEEP) && (r_sweep == '1) && r_report && w_slot_free);

        case (r_state)
            S_IDLE:  w_rd_addr = i_req.hash[BUCKET_BITS-1:0] & w_mask;
            S_CHECK: w_rd_addr = w_fin ? w_b : (n_idx[BUCKET_BITS-1:0] & w_mask);
            default: w_rd_addr = w_b;
        endcase

        w_we      = 1'b0;
        w_wr_addr = w_b;
        w_wr_data = '{used: 1'b1, hash: r_hash, key: r_key, value: r_val};
        if (r_state == S_SWEEP) begin
            w_we      = 1'b1;
            w_wr_addr = r_sweep;
            w_wr_data = '0;
        end else if (w_do_ins) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cfg       <= CFG_RESET;
            r_sweep     <= '0;
            r_report    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_SWEEP: begin
                    if (r_sweep == '1) begin
                        if (!r_report) begin
                            r_state <= S_IDLE;
                        end else if (w_slot_free) begin
                            r_status    <= ST_CLEARED;
                            r_bucket    <= '0;
                            r_value     <= '0;
                            r_report    <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_sweep <= r_sweep + BUCKET_BITS'(1);
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_idx   <= i_req.hash;
                        r_pert  <= i_req.hash;
                        r_hash  <= i_req.hash;
                        r_key   <= w_key_in[KEY_WIDTH-1:0];
                        r_val   <= w_val_in[VALUE_WIDTH-1:0];
                        r_ins   <= (t_func'(i_req.func) == FN_INSERT);
                        r_steps <= '0;
                        if (t_func'(i_req.func) == FN_CLEAR) begin
                            r_count  <= '0;
                            r_sweep  <= '0;
                            r_report <= 1'b1;
                            r_state  <= S_SWEEP;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_fin) begin
                        if (w_slot_free) begin
                            r_status    <= w_status;
                            r_bucket    <= w_bucket;
                            r_value     <= w_value;
                            if (w_do_ins) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= n_idx;
                        r_pert  <= n_pert;
                        r_steps <= r_steps + STEP_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
